### rtl/dsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Beat types, request and status codes and register indexes shared by the
// allocator core, its free stack and its checker.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int ADDR_W   = 48;
    localparam int STRIDE_W = 9;
    localparam int LIMIT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int ACTIVE_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_SLOT     = 2'd1,
        ST_NONE_ACTIVE = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 2'd2;

    typedef struct packed {
        logic [0:0]         opcode;
        logic [INDEX_W-1:0] freed_index;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  slot_index;
        logic [ADDR_W-1:0]   slot_address;
        logic [STATUS_W-1:0] status;
        logic [ACTIVE_W-1:0] active_slots;
    } rsp_t;

    // Control from the core to the free stack; never both in one cycle
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

### rtl/descriptor_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor slot allocator core
// Grants slot indices from a bump counter, then from a LIFO of freed slots,
// and returns each granted slot's address, base plus index times stride.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while the result side is not stalled. Each
// accepted request is captured in the input register, which feeds the result
// register directly. While a result beat is stalled, the request behind it
// waits in the input register. The top of the free stack is kept in a
// register while the RAM read port prefetches the entry beneath it.
// Address generation is a 10 by 9 bit multiply and a 48 bit add.
// Configuration must be written only while no request is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_core #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dsa_pkg::req_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output dsa_pkg::rsp_t                 out_data
);

    import dsa_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic [ADDR_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                in_valid_reg;
    logic                in_valid_next;
    req_t                in_data_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rsp_t                out_data_reg;
    rsp_t                out_data_next;

    logic [CW-1:0]       fresh_reg;
    logic [CW-1:0]       fresh_next;
    logic [CW-1:0]       active_reg;
    logic [CW-1:0]       active_next;

    logic                fire;
    logic                accept;
    logic                granted;
    logic [31:0]         limit_wide;
    logic [CW-1:0]       limit;
    logic [31:0]         fresh_wide;
    logic [31:0]         active_wide;
    logic [INDEX_W-1:0]  idx;
    logic [INDEX_W+STRIDE_W-1:0] offset;
    stk_ctrl_t           stk_ctrl;
    logic [INDEX_W-1:0]  stk_top;
    logic [CW-1:0]       stk_count;

    // Pipeline control: a result register frees up when it is taken
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign limit_wide = (32'(limit_reg) < 32'(POOL_DEPTH)) ? 32'(limit_reg) : 32'(POOL_DEPTH);
    assign limit      = limit_wide[CW-1:0];
    assign fresh_wide = 32'(fresh_reg);

    always_comb
    begin
        fresh_next    = fresh_reg;
        active_next   = active_reg;
        stk_ctrl      = '0;
        idx           = '0;
        granted       = 1'b0;
        out_data_next = '0;
        out_data_next.status = ST_OK;
        if (in_data_reg.opcode == OP_ALLOC)
        begin
            if (fresh_reg < limit)
            begin
                idx         = fresh_wide[INDEX_W-1:0];
                granted     = 1'b1;
                fresh_next  = fresh_reg + CW'(1);
                active_next = active_reg + CW'(1);
            end
            else if (stk_count != '0)
            begin
                idx          = stk_top;
                granted      = 1'b1;
                stk_ctrl.pop = fire;
                active_next  = active_reg + CW'(1);
            end
            else
            begin
                out_data_next.status = ST_NO_SLOT;
            end
        end
        else
        begin
            if (active_reg == '0)
            begin
                out_data_next.status = ST_NONE_ACTIVE;
            end
            else
            begin
                // Drop the push if the stack is somehow full
                stk_ctrl.push = fire && (stk_count < CW'(POOL_DEPTH));
                active_next   = active_reg - CW'(1);
            end
        end
        active_wide                = 32'(active_next);
        out_data_next.slot_index   = idx;
        out_data_next.slot_address = granted ? (base_reg + ADDR_W'(offset)) : '0;
        out_data_next.active_slots = active_wide[ACTIVE_W-1:0];
    end

    assign offset = idx * stride_reg;

    dsa_free_stack #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (stk_ctrl),
        .push_data (in_data_reg.freed_index),
        .top       (stk_top),
        .count     (stk_count)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            stride_reg    <= STRIDE_RESET;
            limit_reg     <= LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fresh_reg     <= '0;
            active_reg    <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_HEAP_BASE))
            begin
                base_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_SLOT_STRIDE))
            begin
                stride_reg <= cfg_data[STRIDE_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_SLOT_LIMIT))
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                fresh_reg  <= fresh_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/dsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered. A read of the
// address being written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module dsa_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dsa_free_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free slot stack
// LIFO of returned slot indices. The top entry lives in a register; the rest
// sit in a RAM whose read port always fetches the entry just below the top,
// so a pop every cycle is possible.
// ----------------------------------------------------------------------------
module dsa_free_stack #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dsa_pkg::stk_ctrl_t                ctrl,
    input  logic [dsa_pkg::INDEX_W-1:0]       push_data,
    output logic [dsa_pkg::INDEX_W-1:0]       top,
    output logic [$clog2(POOL_DEPTH+1)-1:0]   count
);

    import dsa_pkg::*;

    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int AW = $clog2(POOL_DEPTH);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [INDEX_W-1:0] top_reg;
    logic [INDEX_W-1:0] top_next;
    logic               byp_valid_reg;
    logic               byp_valid_next;
    logic [INDEX_W-1:0] byp_data_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [CW-1:0]      count_less_one;
    logic [CW-1:0]      count_less_two;
    logic [INDEX_W-1:0] ram_rdata;
    logic [INDEX_W-1:0] second;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = push_data;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
            top_next   = second;
        end
    end

    // Spill the old top into the RAM when a push covers it
    assign count_less_one = count_reg - CW'(1);
    assign count_less_two = count_next - CW'(2);
    assign ram_we         = ctrl.push && (count_reg != '0);
    assign ram_waddr      = count_less_one[AW-1:0];
    assign ram_raddr      = count_less_two[AW-1:0];
    assign byp_valid_next = ram_we && (ram_waddr == ram_raddr);

    // Forward a same-cycle write to the entry below the top
    assign second = byp_valid_reg ? byp_data_reg : ram_rdata;

    dsa_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (POOL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
    end

    assign top   = top_reg;
    assign count = count_reg;

endmodule

### rtl/dsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor slot allocator checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module dsa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  dsa_pkg::req_t                 in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  dsa_pkg::rsp_t                 out_data
);

    import dsa_pkg::*;

    // A stalled request beat stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("request beat changed while stalled");

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // Requests only back up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled with result side free");

    // Refused requests grant nothing
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK)
        |-> (out_data.slot_index == '0) && (out_data.slot_address == '0))
        else $error("refused request carries an index or address");

    // A free with none active leaves the count at zero
    a_none_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_NONE_ACTIVE) |-> (out_data.active_slots == '0))
        else $error("free with none active reports active slots");

endmodule

bind descriptor_slot_allocator_core dsa_checker u_dsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
